// File: rtl/c8lae_pkg.sv
// ----------------------------------------------------------------------------
// c8lae_pkg: shared types and codes for the 8-bit CPU load/ALU execute block
// Operation classes, address modes and the decoded request record.
// ----------------------------------------------------------------------------
package c8lae_pkg;

	typedef enum logic [1:0] {
		FN_EXEC = 2'd0,
		FN_MWR  = 2'd1,
		FN_MRD  = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MWR,
		OP_MRD,
		OP_UNK,
		OP_LD_RR,
		OP_LD_RI,
		OP_ALU,
		OP_ALU_I,
		OP_LD_A,
		OP_ST_A,
		OP_LD16,
		OP_LD_SPHL,
		OP_LDHL,
		OP_ST_SP,
		OP_PUSH,
		OP_POP
	} op_t;

	typedef enum logic [3:0] {
		AM_BC,
		AM_DE,
		AM_HL,
		AM_IMM,
		AM_FFC,
		AM_FFIMM,
		AM_SP,
		AM_PUSH,
		AM_MEM
	} am_t;

	typedef enum logic [1:0] {
		ADJ_NONE,
		ADJ_INC,
		ADJ_DEC
	} adj_t;

	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_A,
		BS_B
	} bstate_t;

	typedef struct packed {
		op_t         op;
		am_t         am;
		adj_t        adj;
		logic [7:0]  opc;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [15:0] maddr;
		logic [7:0]  mval;
	} dec_t;

	// Operand register codes; code 6 selects the byte at [HL].
	localparam logic [2:0] RC_B   = 3'd0;
	localparam logic [2:0] RC_C   = 3'd1;
	localparam logic [2:0] RC_D   = 3'd2;
	localparam logic [2:0] RC_E   = 3'd3;
	localparam logic [2:0] RC_H   = 3'd4;
	localparam logic [2:0] RC_L   = 3'd5;
	localparam logic [2:0] RC_HLM = 3'd6;
	localparam logic [2:0] RC_A   = 3'd7;

	localparam logic [1:0] PR_BC   = 2'd0;
	localparam logic [1:0] PR_DE   = 2'd1;
	localparam logic [1:0] PR_HL   = 2'd2;
	localparam logic [1:0] PR_SPAF = 2'd3;

	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_ADC = 2'd1;
	localparam logic [1:0] ALU_SUB = 2'd2;

	localparam logic [7:0] OPC_HALT    = 8'h76;
	localparam logic [7:0] OPC_ADD_I   = 8'hC6;
	localparam logic [7:0] OPC_ADC_I   = 8'hCE;
	localparam logic [7:0] OPC_SUB_I   = 8'hD6;
	localparam logic [7:0] OPC_LD_A_BC = 8'h0A;
	localparam logic [7:0] OPC_LD_A_DE = 8'h1A;
	localparam logic [7:0] OPC_ST_BC   = 8'h02;
	localparam logic [7:0] OPC_ST_DE   = 8'h12;
	localparam logic [7:0] OPC_LD_A_NN = 8'hFA;
	localparam logic [7:0] OPC_ST_NN   = 8'hEA;
	localparam logic [7:0] OPC_LD_A_FC = 8'hF2;
	localparam logic [7:0] OPC_ST_FC   = 8'hE2;
	localparam logic [7:0] OPC_LD_A_HD = 8'h3A;
	localparam logic [7:0] OPC_ST_HD   = 8'h32;
	localparam logic [7:0] OPC_LD_A_HI = 8'h2A;
	localparam logic [7:0] OPC_ST_HI   = 8'h22;
	localparam logic [7:0] OPC_ST_FN   = 8'hE0;
	localparam logic [7:0] OPC_LD_A_FN = 8'hF0;
	localparam logic [7:0] OPC_LD_BC   = 8'h01;
	localparam logic [7:0] OPC_LD_DE   = 8'h11;
	localparam logic [7:0] OPC_LD_HL   = 8'h21;
	localparam logic [7:0] OPC_LD_SP   = 8'h31;
	localparam logic [7:0] OPC_SP_HL   = 8'hF9;
	localparam logic [7:0] OPC_LDHL    = 8'hF8;
	localparam logic [7:0] OPC_ST_SP   = 8'h08;
	localparam logic [7:0] OPC_PUSH_AF = 8'hF5;
	localparam logic [7:0] OPC_PUSH_BC = 8'hC5;
	localparam logic [7:0] OPC_PUSH_DE = 8'hD5;
	localparam logic [7:0] OPC_PUSH_HL = 8'hE5;
	localparam logic [7:0] OPC_POP_AF  = 8'hF1;
	localparam logic [7:0] OPC_POP_BC  = 8'hC1;
	localparam logic [7:0] OPC_POP_DE  = 8'hD1;
	localparam logic [7:0] OPC_POP_HL  = 8'hE1;

	localparam int Q_DEPTH = 2;

endpackage

// File: rtl/c8lae_front.sv
// ----------------------------------------------------------------------------
// c8lae_front: request intake and classification
// Registers each request, classifies its opcode and address mode, and pushes it.
// ----------------------------------------------------------------------------
module c8lae_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [7:0]        opcode,
	input  logic [7:0]        imm_low,
	input  logic [7:0]        imm_high,
	input  logic [15:0]       mem_address,
	input  logic [7:0]        mem_value,
	input  logic              clearing,
	input  logic              q_full,
	output logic              q_push,
	output c8lae_pkg::dec_t   q_data
);
	import c8lae_pkg::*;

	logic v_s1;
	dec_t d_s1;
	dec_t dec;
	logic take;

	always_comb begin
		dec.op    = OP_UNK;
		dec.am    = AM_HL;
		dec.adj   = ADJ_NONE;
		dec.opc   = opcode;
		dec.lo    = imm_low;
		dec.hi    = imm_high;
		dec.maddr = mem_address;
		dec.mval  = mem_value;
		case (func_t'(func))
			FN_MWR: begin
				dec.op = OP_MWR;
				dec.am = AM_MEM;
			end
			FN_MRD: begin
				dec.op = OP_MRD;
				dec.am = AM_MEM;
			end
			FN_EXEC: begin
				if (opcode inside {[8'h40:8'h7F]}) begin
					dec.op = (opcode == OPC_HALT) ? OP_UNK : OP_LD_RR;
				end else if (opcode < 8'h40 && (opcode & 8'hC7) == 8'h06) begin
					dec.op = OP_LD_RI;
				end else if (opcode inside {[8'h80:8'h97]}) begin
					dec.op = OP_ALU;
				end else begin
					case (opcode)
						OPC_ADD_I, OPC_ADC_I, OPC_SUB_I: dec.op = OP_ALU_I;
						OPC_LD_A_BC: begin dec.op = OP_LD_A; dec.am = AM_BC; end
						OPC_LD_A_DE: begin dec.op = OP_LD_A; dec.am = AM_DE; end
						OPC_LD_A_NN: begin dec.op = OP_LD_A; dec.am = AM_IMM; end
						OPC_LD_A_FC: begin dec.op = OP_LD_A; dec.am = AM_FFC; end
						OPC_LD_A_FN: begin dec.op = OP_LD_A; dec.am = AM_FFIMM; end
						OPC_LD_A_HD: begin dec.op = OP_LD_A; dec.adj = ADJ_DEC; end
						OPC_LD_A_HI: begin dec.op = OP_LD_A; dec.adj = ADJ_INC; end
						OPC_ST_BC: begin dec.op = OP_ST_A; dec.am = AM_BC; end
						OPC_ST_DE: begin dec.op = OP_ST_A; dec.am = AM_DE; end
						OPC_ST_NN: begin dec.op = OP_ST_A; dec.am = AM_IMM; end
						OPC_ST_FC: begin dec.op = OP_ST_A; dec.am = AM_FFC; end
						OPC_ST_FN: begin dec.op = OP_ST_A; dec.am = AM_FFIMM; end
						OPC_ST_HD: begin dec.op = OP_ST_A; dec.adj = ADJ_DEC; end
						OPC_ST_HI: begin dec.op = OP_ST_A; dec.adj = ADJ_INC; end
						OPC_LD_BC, OPC_LD_DE, OPC_LD_HL, OPC_LD_SP: dec.op = OP_LD16;
						OPC_SP_HL: dec.op = OP_LD_SPHL;
						OPC_LDHL: dec.op = OP_LDHL;
						OPC_ST_SP: begin dec.op = OP_ST_SP; dec.am = AM_IMM; end
						OPC_PUSH_AF, OPC_PUSH_BC, OPC_PUSH_DE, OPC_PUSH_HL: begin
							dec.op = OP_PUSH;
							dec.am = AM_PUSH;
						end
						OPC_POP_AF, OPC_POP_BC, OPC_POP_DE, OPC_POP_HL: begin
							dec.op = OP_POP;
							dec.am = AM_SP;
						end
						default: dec.op = OP_UNK;
					endcase
				end
			end
			default: dec.op = OP_NONE;
		endcase
	end

	assign in_stall = clearing || (v_s1 && q_full);
	assign take     = in_valid && !in_stall;
	assign q_push   = v_s1 && !q_full;
	assign q_data   = d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			d_s1 <= dec;
		end
	end

endmodule

// File: rtl/c8lae_queue.sv
// ----------------------------------------------------------------------------
// c8lae_queue: short request queue between front and back
// Holds classified requests so that intake and execution stall independently.
// ----------------------------------------------------------------------------
module c8lae_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  c8lae_pkg::dec_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output c8lae_pkg::dec_t head
);
	import c8lae_pkg::*;

	localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW = $clog2(Q_DEPTH + 1);

	dec_t             ent_q [Q_DEPTH];
	logic [QAW-1:0]   wp_q;
	logic [QAW-1:0]   rp_q;
	logic [QCW-1:0]   cnt_q;

	assign full       = (cnt_q == QCW'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(Q_DEPTH - 1)) ? '0 : wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == QAW'(Q_DEPTH - 1)) ? '0 : rp_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

endmodule

// File: rtl/c8lae_back.sv
// ----------------------------------------------------------------------------
// c8lae_back: execution unit with register file, byte memory and result register
// Runs each request through a first and a second memory cycle and holds the result for the receiver.
// ----------------------------------------------------------------------------
module c8lae_back #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  c8lae_pkg::dec_t q_head,
	output logic            q_pop,
	output logic            clearing,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      reg_a,
	output logic [7:0]      reg_b,
	output logic [7:0]      reg_c,
	output logic [7:0]      reg_d,
	output logic [7:0]      reg_e,
	output logic [7:0]      reg_h,
	output logic [7:0]      reg_l,
	output logic [15:0]     stack_ptr,
	output logic [3:0]      flag_out,
	output logic [7:0]      read_value,
	output logic            opcode_unknown
);
	import c8lae_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	bstate_t st_q, st_nxt;
	logic [AW-1:0] clr_q;
	dec_t cur_q;
	logic [AW-1:0] a1_q;
	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rd0_q, rd1_q;

	logic [7:0] a_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [15:0] sp_q;
	logic [3:0] f_q;
	logic ovalid_q, unk_q;
	logic [7:0] rdv_q;

	logic do_a, commit, out_free;
	logic [15:0] addr0, addr1, hl16, pv_h, pv_c;
	logic wa_en;
	logic [7:0] wa_data;
	logic we;
	logic [AW-1:0] wa;
	logic [7:0] wd;

	logic [7:0] na, nb, nc, nd, ne, nh, nl;
	logic [15:0] nsp;
	logic [3:0] nf;
	logic [7:0] opnd, alu_b, alu_r;
	logic [8:0] sum9;
	logic [4:0] sum5;
	logic cin;
	logic [15:0] ldhl_v, adj_hl;
	logic [4:0] ldhl_h;
	logic [8:0] ldhl_c;

	function automatic logic [7:0] sel8(input logic [2:0] code, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
		input logic [7:0] e, input logic [7:0] h, input logic [7:0] l);
		logic [7:0] v;
		case (code)
			RC_B: v = b;
			RC_C: v = c;
			RC_D: v = d;
			RC_E: v = e;
			RC_H: v = h;
			RC_L: v = l;
			default: v = a;
		endcase
		return v;
	endfunction

	assign hl16     = {h_q, l_q};
	assign out_free = !ovalid_q || !out_stall;

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			BS_CLEAR: if (clr_q == '1) st_nxt = BS_A;
			BS_A:     if (q_valid) st_nxt = BS_B;
			BS_B:     if (out_free) st_nxt = BS_A;
			default:  st_nxt = BS_CLEAR;
		endcase
	end

	always_comb begin
		clearing = (st_q == BS_CLEAR);
		do_a     = (st_q == BS_A) && q_valid;
		q_pop    = do_a;
		commit   = (st_q == BS_B) && out_free;
	end

	// First memory cycle: address, reads and the low store byte.
	always_comb begin
		case (q_head.am)
			AM_BC:    addr0 = {b_q, c_q};
			AM_DE:    addr0 = {d_q, e_q};
			AM_IMM:   addr0 = {q_head.hi, q_head.lo};
			AM_FFC:   addr0 = {8'hFF, c_q};
			AM_FFIMM: addr0 = {8'hFF, q_head.lo};
			AM_SP:    addr0 = sp_q;
			AM_PUSH:  addr0 = sp_q - 16'd2;
			AM_MEM:   addr0 = q_head.maddr;
			default:  addr0 = hl16;
		endcase
		addr1 = addr0 + 16'd1;
		case (q_head.opc[5:4])
			PR_BC:   pv_h = {b_q, c_q};
			PR_DE:   pv_h = {d_q, e_q};
			PR_HL:   pv_h = hl16;
			default: pv_h = {a_q, f_q, 4'b0000};
		endcase
		wa_en   = 1'b0;
		wa_data = 8'h00;
		case (q_head.op)
			OP_MWR: begin
				wa_en   = 1'b1;
				wa_data = q_head.mval;
			end
			OP_LD_RR: begin
				wa_en   = (q_head.opc[5:3] == RC_HLM);
				wa_data = sel8(q_head.opc[2:0], a_q, b_q, c_q, d_q, e_q, h_q, l_q);
			end
			OP_LD_RI: begin
				wa_en   = (q_head.opc[5:3] == RC_HLM);
				wa_data = q_head.lo;
			end
			OP_ST_A: begin
				wa_en   = 1'b1;
				wa_data = a_q;
			end
			OP_ST_SP: begin
				wa_en   = 1'b1;
				wa_data = sp_q[7:0];
			end
			OP_PUSH: begin
				wa_en   = 1'b1;
				wa_data = pv_h[7:0];
			end
			default: wa_en = 1'b0;
		endcase
	end

	always_comb begin
		case (cur_q.opc[5:4])
			PR_BC:   pv_c = {b_q, c_q};
			PR_DE:   pv_c = {d_q, e_q};
			PR_HL:   pv_c = hl16;
			default: pv_c = {a_q, f_q, 4'b0000};
		endcase
		we = 1'b0;
		wa = a1_q;
		wd = 8'h00;
		if (st_q == BS_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
		end else if (do_a) begin
			we = wa_en;
			wa = addr0[AW-1:0];
			wd = wa_data;
		end else if (commit) begin
			we = (cur_q.op == OP_ST_SP) || (cur_q.op == OP_PUSH);
			wd = (cur_q.op == OP_ST_SP) ? sp_q[15:8] : pv_c[15:8];
		end
	end

	// Second memory cycle: register, SP and flag updates.
	always_comb begin
		na = a_q; nb = b_q; nc = c_q; nd = d_q; ne = e_q; nh = h_q; nl = l_q;
		nsp = sp_q;
		nf = f_q;
		opnd  = (cur_q.opc[2:0] == RC_HLM) ? rd0_q
			: sel8(cur_q.opc[2:0], a_q, b_q, c_q, d_q, e_q, h_q, l_q);
		alu_b = (cur_q.op == OP_ALU_I) ? cur_q.lo : opnd;
		cin   = (cur_q.opc[4:3] == ALU_ADC) ? f_q[0] : 1'b0;
		sum9  = {1'b0, a_q} + {1'b0, alu_b} + {8'd0, cin};
		sum5  = {1'b0, a_q[3:0]} + {1'b0, alu_b[3:0]} + {4'd0, cin};
		ldhl_v = sp_q + {{8{cur_q.lo[7]}}, cur_q.lo};
		ldhl_h = {1'b0, sp_q[3:0]} + {1'b0, cur_q.lo[3:0]};
		ldhl_c = {1'b0, sp_q[7:0]} + {1'b0, cur_q.lo};
		case (cur_q.adj)
			ADJ_INC: adj_hl = hl16 + 16'd1;
			ADJ_DEC: adj_hl = hl16 - 16'd1;
			default: adj_hl = hl16;
		endcase
		if (cur_q.opc[4:3] == ALU_SUB) begin
			alu_r = a_q - alu_b;
		end else begin
			alu_r = sum9[7:0];
		end
		case (cur_q.op)
			OP_LD_RR, OP_LD_RI: begin
				case (cur_q.opc[5:3])
					RC_B: nb = (cur_q.op == OP_LD_RI) ? cur_q.lo : opnd;
					RC_C: nc = (cur_q.op == OP_LD_RI) ? cur_q.lo : opnd;
					RC_D: nd = (cur_q.op == OP_LD_RI) ? cur_q.lo : opnd;
					RC_E: ne = (cur_q.op == OP_LD_RI) ? cur_q.lo : opnd;
					RC_H: nh = (cur_q.op == OP_LD_RI) ? cur_q.lo : opnd;
					RC_L: nl = (cur_q.op == OP_LD_RI) ? cur_q.lo : opnd;
					RC_A: na = (cur_q.op == OP_LD_RI) ? cur_q.lo : opnd;
					default: na = a_q;
				endcase
			end
			OP_ALU, OP_ALU_I: begin
				na = alu_r;
				if (cur_q.opc[4:3] == ALU_SUB) begin
					nf = {alu_r == 8'd0, 1'b1, a_q[3:0] < alu_b[3:0], a_q < alu_b};
				end else begin
					nf = {alu_r == 8'd0, 1'b0, sum5[4], sum9[8]};
				end
			end
			OP_LD_A: begin
				na = rd0_q;
				{nh, nl} = adj_hl;
			end
			OP_ST_A: {nh, nl} = adj_hl;
			OP_LD16: begin
				case (cur_q.opc[5:4])
					PR_BC:   {nb, nc} = {cur_q.hi, cur_q.lo};
					PR_DE:   {nd, ne} = {cur_q.hi, cur_q.lo};
					PR_HL:   {nh, nl} = {cur_q.hi, cur_q.lo};
					default: nsp = {cur_q.hi, cur_q.lo};
				endcase
			end
			OP_LD_SPHL: nsp = hl16;
			OP_LDHL: begin
				{nh, nl} = ldhl_v;
				nf = {2'b00, ldhl_h[4], ldhl_c[8]};
			end
			OP_PUSH: nsp = sp_q - 16'd2;
			OP_POP: begin
				nsp = sp_q + 16'd2;
				case (cur_q.opc[5:4])
					PR_BC: {nb, nc} = {rd1_q, rd0_q};
					PR_DE: {nd, ne} = {rd1_q, rd0_q};
					PR_HL: {nh, nl} = {rd1_q, rd0_q};
					default: begin
						na = rd1_q;
						nf = rd0_q[7:4];
					end
				endcase
			end
			default: na = a_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BS_CLEAR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			e_q <= '0; h_q <= '0; l_q <= '0;
			sp_q <= '0;
			f_q  <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == BS_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (commit) begin
				ovalid_q <= 1'b1;
				a_q <= na; b_q <= nb; c_q <= nc; d_q <= nd;
				e_q <= ne; h_q <= nh; l_q <= nl;
				sp_q <= nsp;
				f_q  <= nf;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_a) begin
			cur_q <= q_head;
			a1_q  <= addr1[AW-1:0];
			rd0_q <= mem[addr0[AW-1:0]];
			rd1_q <= mem[addr1[AW-1:0]];
		end
		if (commit) begin
			rdv_q <= (cur_q.op == OP_MRD) ? rd0_q : 8'h00;
			unk_q <= (cur_q.op == OP_UNK);
		end
		if (we) begin
			mem[wa] <= wd;
		end
	end

	assign out_valid      = ovalid_q;
	assign reg_a          = a_q;
	assign reg_b          = b_q;
	assign reg_c          = c_q;
	assign reg_d          = d_q;
	assign reg_e          = e_q;
	assign reg_h          = h_q;
	assign reg_l          = l_q;
	assign stack_ptr      = sp_q;
	assign flag_out       = f_q;
	assign read_value     = rdv_q;
	assign opcode_unknown = unk_q;

endmodule

// File: rtl/cpu8_load_alu_execute.sv
// ----------------------------------------------------------------------------
// cpu8_load_alu_execute: load, stack and ADD/ADC/SUB execute block
// Executes one instruction, memory write or memory read per request.
// ----------------------------------------------------------------------------
// The input channel takes one request per accepted transfer: func selects
// instruction execution, a memory byte write or a memory byte read. The
// output channel returns one result per request with the registers, SP and
// flags after it, the byte read and an unknown-opcode mark, in request order.
// A request passes the intake register, the queue and the back end's
// BS_A and BS_B states before it reaches the result register. The back
// end takes one request at a time, one state per port cycle of the byte
// memory. A two-entry queue sits between intake and execution. After
// reset the byte memory is cleared, one byte per cycle; in_stall stays
// high during that pass. When out_stall is high the result is held,
// execution waits, and intake stalls once the queue and the intake
// register are full. MEM_DEPTH must be a power of two; it is not checked.
// ----------------------------------------------------------------------------
module cpu8_load_alu_execute #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  opcode,
	input  logic [7:0]  imm_low,
	input  logic [7:0]  imm_high,
	input  logic [15:0] mem_address,
	input  logic [7:0]  mem_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  reg_a,
	output logic [7:0]  reg_b,
	output logic [7:0]  reg_c,
	output logic [7:0]  reg_d,
	output logic [7:0]  reg_e,
	output logic [7:0]  reg_h,
	output logic [7:0]  reg_l,
	output logic [15:0] stack_ptr,
	output logic [3:0]  flag_out,
	output logic [7:0]  read_value,
	output logic        opcode_unknown
);
	import c8lae_pkg::*;

	logic clearing, q_full, q_push, q_pop, q_valid;
	dec_t q_data, q_head;

	c8lae_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.opcode      (opcode),
		.imm_low     (imm_low),
		.imm_high    (imm_high),
		.mem_address (mem_address),
		.mem_value   (mem_value),
		.clearing    (clearing),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	c8lae_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	c8lae_back #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.reg_a          (reg_a),
		.reg_b          (reg_b),
		.reg_c          (reg_c),
		.reg_d          (reg_d),
		.reg_e          (reg_e),
		.reg_h          (reg_h),
		.reg_l          (reg_l),
		.stack_ptr      (stack_ptr),
		.flag_out       (flag_out),
		.read_value     (read_value),
		.opcode_unknown (opcode_unknown)
	);

endmodule

// File: rtl/c8lae_checker.sv
// ----------------------------------------------------------------------------
// c8lae_checker: port-level checks for the execute block
// Watches the result channel and its timing.
// ----------------------------------------------------------------------------
module c8lae_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  reg_a,
	input logic [15:0] stack_ptr,
	input logic [7:0]  read_value,
	input logic        opcode_unknown
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result dropped while the receiver stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(reg_a) && $stable(stack_ptr))
		else $error("Stalled result changed.");

	a_unknown_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && opcode_unknown |-> read_value == 8'h00)
		else $error("Unknown opcode result carries a read byte.");

endmodule

bind cpu8_load_alu_execute c8lae_checker u_chk (.*);

// File: test/cpu8_load_alu_execute_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_load_alu_execute_test: self-checking regression for the execute block
// Requests go in through a bursty driver; each whole result is compared
// against an in-bench model of registers, SP, flags and byte memory.
// ----------------------------------------------------------------------------
module cpu8_load_alu_execute_test;
	import c8lae_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  fn;
		logic [7:0]  opc;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [15:0] addr;
		logic [7:0]  val;
	} request_t;

	typedef struct packed {
		logic [7:0]  a, b, c, d, e, h, l;
		logic [15:0] sp;
		logic [3:0]  flags;
		logic [7:0]  rd;
		logic        unk;
	} cpu_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FN_EXEC;
	logic [7:0] opcode = 8'd0, imm_low = 8'd0, imm_high = 8'd0, mem_value = 8'd0;
	logic [15:0] mem_address = 16'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l, read_value;
	logic [15:0] stack_ptr;
	logic [3:0] flag_out;
	logic opcode_unknown;

	request_t pending_requests[$];
	cpu_view_t expected_views[$];
	logic [7:0] mdl_reg[8];
	logic [15:0] mdl_sp;
	logic [3:0] mdl_flags;
	logic [7:0] mdl_mem[65536];
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit stimulus_done = 0;

	cpu8_load_alu_execute dut (.*);

	always #6 clk = ~clk;

	function automatic logic [7:0] operand(logic [2:0] code);
		if (code == RC_HLM)
			return mdl_mem[{mdl_reg[RC_H], mdl_reg[RC_L]}];
		return mdl_reg[code];
	endfunction

	function automatic void alu_op(logic [1:0] kind, logic [7:0] b);
		logic [8:0] s;
		logic [4:0] hs;
		logic cin;
		logic [3:0] f;
		f = 4'd0;
		if (kind == ALU_SUB) begin
			s = {1'b0, mdl_reg[RC_A]} - {1'b0, b};
			f[2] = 1'b1;
			f[1] = mdl_reg[RC_A][3:0] < b[3:0];
			f[0] = mdl_reg[RC_A] < b;
		end else begin
			cin = (kind == ALU_ADC) ? mdl_flags[0] : 1'b0;
			s = {1'b0, mdl_reg[RC_A]} + {1'b0, b} + {8'd0, cin};
			hs = {1'b0, mdl_reg[RC_A][3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
			f[1] = hs[4];
			f[0] = s[8];
		end
		f[3] = s[7:0] == 8'd0;
		mdl_reg[RC_A] = s[7:0];
		mdl_flags = f;
	endfunction

	function automatic void push_word(logic [15:0] v);
		mdl_sp = mdl_sp - 16'd2;
		mdl_mem[mdl_sp] = v[7:0];
		mdl_mem[mdl_sp + 16'd1] = v[15:8];
	endfunction

	function automatic logic [15:0] pop_word();
		logic [15:0] v;
		v = {mdl_mem[mdl_sp + 16'd1], mdl_mem[mdl_sp]};
		mdl_sp = mdl_sp + 16'd2;
		return v;
	endfunction

	function automatic void set_pair(logic [2:0] hi, logic [15:0] v);
		mdl_reg[hi] = v[15:8];
		mdl_reg[hi + 3'd1] = v[7:0];
	endfunction

	function automatic bit run_opcode(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
		logic [15:0] nn, hl, bc, de;
		logic [4:0] hs;
		logic [8:0] cs;
		nn = {hi, lo};
		hl = {mdl_reg[RC_H], mdl_reg[RC_L]};
		bc = {mdl_reg[RC_B], mdl_reg[RC_C]};
		de = {mdl_reg[RC_D], mdl_reg[RC_E]};
		if (op >= 8'h40 && op <= 8'h7F) begin
			if (op == OPC_HALT)
				return 0;
			if (op[5:3] == RC_HLM)
				mdl_mem[hl] = operand(op[2:0]);
			else
				mdl_reg[op[5:3]] = operand(op[2:0]);
			return 1;
		end
		if (op < 8'h40 && op[2:0] == 3'd6) begin
			if (op[5:3] == RC_HLM)
				mdl_mem[hl] = lo;
			else
				mdl_reg[op[5:3]] = lo;
			return 1;
		end
		if (op >= 8'h80 && op <= 8'h97) begin
			alu_op(op[4:3], operand(op[2:0]));
			return 1;
		end
		case (op)
			OPC_ADD_I: alu_op(ALU_ADD, lo);
			OPC_ADC_I: alu_op(ALU_ADC, lo);
			OPC_SUB_I: alu_op(ALU_SUB, lo);
			OPC_LD_A_BC: mdl_reg[RC_A] = mdl_mem[bc];
			OPC_LD_A_DE: mdl_reg[RC_A] = mdl_mem[de];
			OPC_ST_BC: mdl_mem[bc] = mdl_reg[RC_A];
			OPC_ST_DE: mdl_mem[de] = mdl_reg[RC_A];
			OPC_LD_A_NN: mdl_reg[RC_A] = mdl_mem[nn];
			OPC_ST_NN: mdl_mem[nn] = mdl_reg[RC_A];
			OPC_LD_A_FC: mdl_reg[RC_A] = mdl_mem[{8'hFF, mdl_reg[RC_C]}];
			OPC_ST_FC: mdl_mem[{8'hFF, mdl_reg[RC_C]}] = mdl_reg[RC_A];
			OPC_LD_A_HD: begin
				mdl_reg[RC_A] = mdl_mem[hl];
				set_pair(RC_H, hl - 16'd1);
			end
			OPC_ST_HD: begin
				mdl_mem[hl] = mdl_reg[RC_A];
				set_pair(RC_H, hl - 16'd1);
			end
			OPC_LD_A_HI: begin
				mdl_reg[RC_A] = mdl_mem[hl];
				set_pair(RC_H, hl + 16'd1);
			end
			OPC_ST_HI: begin
				mdl_mem[hl] = mdl_reg[RC_A];
				set_pair(RC_H, hl + 16'd1);
			end
			OPC_ST_FN: mdl_mem[{8'hFF, lo}] = mdl_reg[RC_A];
			OPC_LD_A_FN: mdl_reg[RC_A] = mdl_mem[{8'hFF, lo}];
			OPC_LD_BC: set_pair(RC_B, nn);
			OPC_LD_DE: set_pair(RC_D, nn);
			OPC_LD_HL: set_pair(RC_H, nn);
			OPC_LD_SP: mdl_sp = nn;
			OPC_SP_HL: mdl_sp = hl;
			OPC_LDHL: begin
				hs = {1'b0, mdl_sp[3:0]} + {1'b0, lo[3:0]};
				cs = {1'b0, mdl_sp[7:0]} + {1'b0, lo};
				set_pair(RC_H, mdl_sp + {{8{lo[7]}}, lo});
				mdl_flags = {2'b00, hs[4], cs[8]};
			end
			OPC_ST_SP: begin
				mdl_mem[nn] = mdl_sp[7:0];
				mdl_mem[nn + 16'd1] = mdl_sp[15:8];
			end
			OPC_PUSH_AF: push_word({mdl_reg[RC_A], mdl_flags, 4'd0});
			OPC_PUSH_BC: push_word(bc);
			OPC_PUSH_DE: push_word(de);
			OPC_PUSH_HL: push_word(hl);
			OPC_POP_AF: begin
				nn = pop_word();
				mdl_reg[RC_A] = nn[15:8];
				mdl_flags = nn[7:4];
			end
			OPC_POP_BC: set_pair(RC_B, pop_word());
			OPC_POP_DE: set_pair(RC_D, pop_word());
			OPC_POP_HL: set_pair(RC_H, pop_word());
			default: return 0;
		endcase
		return 1;
	endfunction

	function automatic cpu_view_t apply_request(request_t r);
		cpu_view_t v;
		v.rd = 8'd0;
		v.unk = 1'b0;
		case (r.fn)
			FN_EXEC: v.unk = !run_opcode(r.opc, r.lo, r.hi);
			FN_MWR: mdl_mem[r.addr] = r.val;
			FN_MRD: v.rd = mdl_mem[r.addr];
			default: ;
		endcase
		v.a = mdl_reg[RC_A];
		v.b = mdl_reg[RC_B];
		v.c = mdl_reg[RC_C];
		v.d = mdl_reg[RC_D];
		v.e = mdl_reg[RC_E];
		v.h = mdl_reg[RC_H];
		v.l = mdl_reg[RC_L];
		v.sp = mdl_sp;
		v.flags = mdl_flags;
		return v;
	endfunction

	function automatic void queue_request(logic [1:0] fn, logic [7:0] opc, logic [7:0] lo,
			logic [7:0] hi, logic [15:0] addr, logic [7:0] val);
		pending_requests.push_back({fn, opc, lo, hi, addr, val});
	endfunction

	function automatic logic [7:0] pick_opcode();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1: return 8'h40 + 8'($urandom_range(0, 63));
			2, 3: return 8'h80 + 8'($urandom_range(0, 23));
			4: return {2'b00, 3'($urandom_range(0, 7)), 3'd6};
			5: return $urandom_range(0, 1) ? OPC_PUSH_AF + 8'h10 * 3'($urandom_range(0, 3)) - 8'h30
				: OPC_POP_AF - 8'h10 * 3'($urandom_range(0, 3));
			6: return $urandom_range(0, 1) ? OPC_LDHL : OPC_ST_SP;
			9: return 8'($urandom);
			default: begin
				case ($urandom_range(0, 11))
					0: return OPC_ADD_I;
					1: return OPC_ADC_I;
					2: return OPC_SUB_I;
					3: return OPC_LD_A_BC;
					4: return OPC_ST_DE;
					5: return OPC_LD_A_NN;
					6: return OPC_ST_FC;
					7: return OPC_LD_A_HI;
					8: return OPC_ST_HD;
					9: return OPC_LD_HL;
					10: return OPC_LD_SP;
					default: return OPC_SP_HL;
				endcase
			end
		endcase
	endfunction

	initial begin
		for (int i = 0; i < 8; i++)
			mdl_reg[i] = 8'd0;
		mdl_sp = 16'd0;
		mdl_flags = 4'd0;
		for (int i = 0; i < 65536; i++)
			mdl_mem[i] = 8'd0;

		queue_request(FN_MWR, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'hFF);
		queue_request(FN_MRD, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'h00);
		queue_request(FN_MRD, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
		queue_request(FN_EXEC, OPC_HALT, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, 8'hD3, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, {2'b00, RC_A, 3'd6}, 8'hFF, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_ADD_I, 8'h01, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_ADC_I, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_SUB_I, 8'h01, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_SUB_I, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_LD_SP, 8'h01, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_PUSH_AF, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_POP_BC, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_LD_SP, 8'hFF, 8'hFF, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_POP_AF, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_LDHL, 8'h80, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_LDHL, 8'h7F, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_ST_SP, 8'hFF, 8'hFF, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_ST_HI, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_LD_A_HD, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_ST_FN, 8'hFF, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_LD_A_FC, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, 8'h86, 8'h00, 8'h00, 16'h0000, 8'h00);
		queue_request(FN_EXEC, OPC_ST_BC, 8'h00, 8'h00, 16'h0000, 8'h00);

		// Most random requests are instructions; reads and writes keep memory lively.
		for (int i = 0; i < 750; i++) begin
			case ($urandom_range(0, 9))
				0: queue_request(FN_MWR, 8'($urandom), 8'($urandom), 8'($urandom),
					$urandom_range(0, 1) ? 16'($urandom) : 16'hFF00 | 8'($urandom), 8'($urandom));
				1: queue_request($urandom_range(0, 4) == 0 ? FN_NONE : FN_MRD, 8'($urandom),
					8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
				default: queue_request(FN_EXEC, pick_opcode(), 8'($urandom), 8'($urandom),
					16'($urandom), 8'($urandom));
			endcase
		end
		stimulus_done = 1;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			expected_views.push_back(apply_request({func, opcode, imm_low, imm_high,
				mem_address, mem_value}));
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				request_t r;
				r = pending_requests.pop_front();
				{func, opcode, imm_low, imm_high, mem_address, mem_value} <= r;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(0, 255) < 128) ? ($urandom_range(0, 3) == 0)
				: ($urandom_range(0, 1) == 0);
	end

	always @(posedge clk) begin
		cpu_view_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l, stack_ptr, flag_out,
				read_value, opcode_unknown};
			if (expected_views.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_views.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h, actual %h", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		while (!(stimulus_done && pending_requests.size() == 0 && !in_valid
				&& expected_views.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("cpu8_load_alu_execute regression: fail");
			$finish;
		end else begin
			repeat (20) @(posedge clk);
			if (mismatches == 0 && expected_views.size() == 0)
				$display("cpu8_load_alu_execute regression: pass");
			else
				$display("cpu8_load_alu_execute regression: fail");
			$finish;
		end
	end

endmodule

// File: files.f
rtl/c8lae_pkg.sv
rtl/c8lae_front.sv
rtl/c8lae_queue.sv
rtl/c8lae_back.sv
rtl/cpu8_load_alu_execute.sv
rtl/c8lae_checker.sv
test/cpu8_load_alu_execute_test.sv
